// ----- sv/sra_pkg.sv -----
// ----------------------------------------------------------------------------
// sra_pkg
// Shared widths, codes and types of the sparse row accumulator.
// ----------------------------------------------------------------------------
package sra_pkg;

   localparam int COL_W = 10;
   localparam int VAL_W = 32;

   // operation codes of an input transaction
   localparam logic OP_ACCUM = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef logic [COL_W-1:0]        col_type;
   typedef logic signed [VAL_W-1:0] value_type;

   // one accumulator memory word: list membership flag and running sum
   typedef struct packed {
      logic      touched;
      value_type sum;
   } acc_entry_type;

endpackage

// ----- sv/sra_if.sv -----
// ----------------------------------------------------------------------------
// sra_req_if / sra_rsp_if
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
interface sra_req_if;
   import sra_pkg::*;

   logic      valid;
   logic      ready;
   logic      op;
   col_type   col;
   value_type a_value;
   value_type b_value;

   modport source (output valid, output op, output col, output a_value,
                   output b_value, input ready);
   modport sink   (input valid, input op, input col, input a_value,
                   input b_value, output ready);
endinterface

interface sra_rsp_if;
   import sra_pkg::*;

   logic      valid;
   logic      ready;
   col_type   out_col;
   value_type out_value;
   logic      last;
   logic      valid_res;

   modport source (output valid, output out_col, output out_value, output last,
                   output valid_res, input ready);
   modport sink   (input valid, input out_col, input out_value, input last,
                   input valid_res, output ready);
endinterface

// ----- sv/sra_mac.sv -----
// ----------------------------------------------------------------------------
// sra_mac
// Registered Q-format product, floor shift and saturating add to a sum.
// ----------------------------------------------------------------------------
module sra_mac #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               load,
   input  sra_pkg::value_type a_value,
   input  sra_pkg::value_type b_value,
   input  sra_pkg::value_type acc,
   output sra_pkg::value_type sum
);
   import sra_pkg::*;

   localparam int PROD_W = 2 * VAL_W;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] shifted;
   logic signed [PROD_W-1:0] total;
   logic [PROD_W-VAL_W:0]    top_bits;

   // capture the full product when the transaction is taken
   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= PROD_W'(a_value) * PROD_W'(b_value);
      end
   end

   // arithmetic shift rounds toward minus infinity
   assign shifted  = prod_ff >>> FRAC_BITS;
   assign total    = PROD_W'(acc) + shifted;
   assign top_bits = total[PROD_W-1:VAL_W-1];

   // clamp to the signed 32-bit range
   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         sum = total[VAL_W-1:0];
      end else if (total[PROD_W-1]) begin
         sum = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         sum = {1'b0, {(VAL_W-1){1'b1}}};
      end
   end

endmodule

// ----- sv/sparse_row_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// sparse_row_accumulator_core
// Dense accumulator of a row-wise sparse matrix product with a nonzero list.
// ----------------------------------------------------------------------------
// An accumulate transaction multiplies a_value by b_value (Q-format, floor
// shift by FRAC_BITS) and adds the product, saturated to 32 bits, into the
// accumulator word of its column; a column touched for the first time in the
// row is appended to the column list. A drain transaction returns the next
// listed column with its sum, clears that word and flags the final entry.
// The accumulator words and the column list sit in two synchronous memories,
// each with one read and one write port, with one item in flight: an
// accumulate takes an accumulator read, then add and write back; a drain of
// a listed entry takes a list read, an accumulator read, a clear and an
// output load; a drain of an empty row goes straight to the output load.
// After reset a clearing pass over all min(COLUMNS, 1024) accumulator words
// zeroes the accumulator memory; no request is taken until it ends. A
// finished response waits in an output register while accumulate requests
// continue; a further drain holds in its output load step until that
// register is free.
// ----------------------------------------------------------------------------
module sparse_row_accumulator_core #(
   parameter int COLUMNS   = 1024,
   parameter int FRAC_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   sra_req_if.sink   req,
   sra_rsp_if.source rsp
);
   import sra_pkg::*;

   localparam int ACC_DEPTH = (COLUMNS < (2 ** COL_W)) ? COLUMNS : (2 ** COL_W);
   localparam int ACC_W     = $clog2(ACC_DEPTH);
   localparam int LIST_W    = $clog2(COLUMNS);
   localparam int CNT_W     = $clog2(COLUMNS + 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ACCUM,
      S_DLIST,
      S_DACC,
      S_PUSH
   } state_type;

   state_type state_ff;

   // memories
   acc_entry_type acc_mem [ACC_DEPTH];
   col_type       list_mem [COLUMNS];
   acc_entry_type acc_rd_ff;
   col_type       list_rd_ff;

   logic          acc_wr_en;
   logic [ACC_W-1:0] acc_wr_addr;
   acc_entry_type acc_wr_data;
   logic [ACC_W-1:0] acc_rd_addr;
   logic          list_wr_en;

   // control and payload registers
   logic [ACC_W-1:0] clear_idx_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] pos_ff;
   logic [CNT_W-1:0] pos_next;
   col_type       col_ff;
   col_type       hold_col_ff;
   value_type     hold_value_ff;
   logic          hold_last_ff;
   logic          hold_vld_ff;
   logic          rsp_valid_ff;
   col_type       rsp_col_ff;
   value_type     rsp_value_ff;
   logic          rsp_last_ff;
   logic          rsp_vld_ff;

   logic          accept;
   logic          col_ok;
   logic          list_full;
   logic          slot_free;
   value_type     mac_sum;

   assign req.ready     = (state_ff == S_IDLE);
   assign accept        = req.valid && (state_ff == S_IDLE);
   assign col_ok        = int'(req.col) < ACC_DEPTH;
   assign list_full     = count_ff >= CNT_W'(COLUMNS);
   assign slot_free     = !rsp_valid_ff || rsp.ready;
   assign pos_next      = pos_ff + CNT_W'(1);

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_col   = rsp_col_ff;
   assign rsp.out_value = rsp_value_ff;
   assign rsp.last      = rsp_last_ff;
   assign rsp.valid_res = rsp_vld_ff;

   // multiply at accept, add and saturate on the read data
   sra_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock   (clock),
      .load    (accept),
      .a_value (req.a_value),
      .b_value (req.b_value),
      .acc     (acc_rd_ff.sum),
      .sum     (mac_sum)
   );

   // select the accumulator read address
   assign acc_rd_addr = (state_ff == S_DLIST) ? list_rd_ff[ACC_W-1:0]
                                              : req.col[ACC_W-1:0];

   // select the accumulator write: clearing pass, update or drain clear
   always_comb begin
      acc_wr_en   = 1'b0;
      acc_wr_addr = col_ff[ACC_W-1:0];
      acc_wr_data = '0;
      list_wr_en  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            acc_wr_en   = 1'b1;
            acc_wr_addr = clear_idx_ff;
         end
         S_ACCUM: begin
            if (acc_rd_ff.touched || !list_full) begin
               acc_wr_en   = 1'b1;
               acc_wr_data = '{touched: 1'b1, sum: mac_sum};
               list_wr_en  = !acc_rd_ff.touched;
            end
         end
         S_DACC: begin
            acc_wr_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // accumulator memory
   always_ff @(posedge clock) begin
      if (acc_wr_en) begin
         acc_mem[acc_wr_addr] <= acc_wr_data;
      end
      acc_rd_ff <= acc_mem[acc_rd_addr];
   end

   // column list memory
   always_ff @(posedge clock) begin
      if (list_wr_en) begin
         list_mem[count_ff[LIST_W-1:0]] <= col_ff;
      end
      list_rd_ff <= list_mem[pos_ff[LIST_W-1:0]];
   end

   // sequence one transaction at a time and drive the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_idx_ff <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the response once it is taken, unless the next one loads now
         if (rsp_valid_ff && rsp.ready && (state_ff != S_PUSH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clear_idx_ff <= clear_idx_ff + ACC_W'(1);
               if (clear_idx_ff == ACC_W'(ACC_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  col_ff <= req.col;
                  if (req.op == OP_ACCUM) begin
                     if (col_ok) begin
                        state_ff <= S_ACCUM;
                     end
                  end else if (pos_ff >= count_ff) begin
                     // empty row: rewind and report nothing found
                     count_ff      <= '0;
                     pos_ff        <= '0;
                     hold_col_ff   <= '0;
                     hold_value_ff <= '0;
                     hold_last_ff  <= 1'b1;
                     hold_vld_ff   <= 1'b0;
                     state_ff      <= S_PUSH;
                  end else begin
                     state_ff <= S_DLIST;
                  end
               end
            end
            S_ACCUM: begin
               if (!acc_rd_ff.touched && !list_full) begin
                  count_ff <= count_ff + CNT_W'(1);
               end
               state_ff <= S_IDLE;
            end
            S_DLIST: begin
               col_ff   <= list_rd_ff;
               state_ff <= S_DACC;
            end
            S_DACC: begin
               hold_col_ff   <= col_ff;
               hold_value_ff <= acc_rd_ff.sum;
               hold_vld_ff   <= 1'b1;
               // rewind after the final entry of the row
               if (pos_next >= count_ff) begin
                  hold_last_ff <= 1'b1;
                  count_ff     <= '0;
                  pos_ff       <= '0;
               end else begin
                  hold_last_ff <= 1'b0;
                  pos_ff       <= pos_next;
               end
               state_ff <= S_PUSH;
            end
            S_PUSH: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_col_ff   <= hold_col_ff;
                  rsp_value_ff <= hold_value_ff;
                  rsp_last_ff  <= hold_last_ff;
                  rsp_vld_ff   <= hold_vld_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- dv/sparse_row_accumulator_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_row_accumulator_core_tb
// Self-checking bench for the sparse row accumulator core.
// ----------------------------------------------------------------------------
// A table of directed transactions covers the field extremes, saturation,
// cancellation to zero, re-touch during drain and empty-row drains. Random
// rows of accumulates then drains follow, with a long receiver hold-off in
// between. Each accepted request runs through a dense-row predictor, and
// every response is checked in order against the predicted entries, while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module sparse_row_accumulator_core_tb;
   import sra_pkg::*;

   localparam int COLUMNS   = 1024;
   localparam int FRAC_BITS = 16;

   localparam value_type MAX_Q  = 32'h7FFF_FFFF;
   localparam value_type MIN_Q  = 32'h8000_0000;
   localparam value_type ONE_Q  = 32'h0001_0000;
   localparam value_type NEG1_Q = 32'hFFFF_0000;
   localparam value_type ALL1   = 32'hFFFF_FFFF;

   localparam longint SUM_MAX = 64'sd2147483647;
   localparam longint SUM_MIN = -64'sd2147483648;

   // one response transaction as the bench expects it
   typedef struct packed {
      col_type   col;
      value_type value;
      logic      last;
      logic      valid_res;
   } row_entry_type;

   // one directed request, with a hand-written expectation where lit is set
   typedef struct packed {
      logic      op;
      col_type   col;
      value_type a;
      value_type b;
      logic      lit;
      col_type   x_col;
      value_type x_value;
      logic      x_last;
      logic      x_valid;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [23] = '{
      // empty row straight after reset, then with all unused fields high
      '{OP_DRAIN, 10'd0,    32'h0,   32'h0,   1'b1, 10'd0, 32'h0, 1'b1, 1'b0},
      '{OP_DRAIN, 10'd1023, ALL1,    ALL1,    1'b1, 10'd0, 32'h0, 1'b1, 1'b0},
      '{OP_ACCUM, 10'd0,    ONE_Q,   32'h0002_0000, 1'b0, 10'd0, 32'h0, 1'b0, 1'b0},
      // positive saturation, twice on the same column
      '{OP_ACCUM, 10'd1023, MAX_Q,   MAX_Q,   1'b0, 10'd0, 32'h0, 1'b0, 1'b0},
      '{OP_ACCUM, 10'd1023, MAX_Q,   MAX_Q,   1'b0, 10'd0, 32'h0, 1'b0, 1'b0},
      // negative saturation
      '{OP_ACCUM, 10'd5,    MIN_Q,   MAX_Q,   1'b0, 10'd0, 32'h0, 1'b0, 1'b0},
      // floor of a tiny negative product, then a tiny positive one
      '{OP_ACCUM, 10'd7,    ALL1,    32'h1,   1'b0, 10'd0, 32'h0, 1'b0, 1'b0},
      '{OP_ACCUM, 10'd7,    32'h1,   32'h1,   1'b0, 10'd0, 32'h0, 1'b0, 1'b0},
      // sum that cancels to zero must stay listed once
      '{OP_ACCUM, 10'd9,    ONE_Q,   32'h0003_0000, 1'b0, 10'd0, 32'h0, 1'b0, 1'b0},
      '{OP_ACCUM, 10'd9,    NEG1_Q,  32'h0003_0000, 1'b0, 10'd0, 32'h0, 1'b0, 1'b0},
      '{OP_ACCUM, 10'd9,    32'h0,   32'h0,   1'b0, 10'd0, 32'h0, 1'b0, 1'b0},
      '{OP_DRAIN, 10'd0,    32'h0,   32'h0,   1'b1, 10'd0, 32'h0002_0000, 1'b0, 1'b1},
      '{OP_DRAIN, 10'd0,    32'h0,   32'h0,   1'b1, 10'd1023, MAX_Q, 1'b0, 1'b1},
      '{OP_DRAIN, 10'd0,    32'h0,   32'h0,   1'b1, 10'd5, MIN_Q, 1'b0, 1'b1},
      // re-touch a drained column before the row ends
      '{OP_ACCUM, 10'd0,    ONE_Q,   ONE_Q,   1'b0, 10'd0, 32'h0, 1'b0, 1'b0},
      '{OP_DRAIN, 10'd0,    32'h0,   32'h0,   1'b0, 10'd0, 32'h0, 1'b0, 1'b0},
      '{OP_DRAIN, 10'd0,    32'h0,   32'h0,   1'b1, 10'd9, 32'h0, 1'b0, 1'b1},
      '{OP_DRAIN, 10'd0,    32'h0,   32'h0,   1'b1, 10'd0, ONE_Q, 1'b1, 1'b1},
      '{OP_DRAIN, 10'd0,    32'h0,   32'h0,   1'b1, 10'd0, 32'h0, 1'b1, 1'b0},
      '{OP_ACCUM, 10'h155,  MIN_Q,   MIN_Q,   1'b0, 10'd0, 32'h0, 1'b0, 1'b0},
      '{OP_ACCUM, 10'h2AA,  ALL1,    MIN_Q,   1'b0, 10'd0, 32'h0, 1'b0, 1'b0},
      '{OP_DRAIN, 10'd0,    32'h0,   32'h0,   1'b1, 10'h155, MAX_Q, 1'b0, 1'b1},
      '{OP_DRAIN, 10'h3FF,  ALL1,    ALL1,    1'b0, 10'd0, 32'h0, 1'b0, 1'b0}
   };

   logic clock = 1'b0;
   logic reset;

   sra_req_if req_if ();
   sra_rsp_if rsp_if ();

   sparse_row_accumulator_core #(
      .COLUMNS  (COLUMNS),
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if)
   );

   // dense row state of the predictor
   value_type dense_sum   [COLUMNS];
   logic      col_touched [COLUMNS];
   col_type   nz_cols     [COLUMNS];
   int        list_len  = 0;
   int        drain_pos = 0;

   row_entry_type pending_entries [$];

   int sent_count    = 0;
   int error_count   = 0;
   int req_idle_pct  = 0;
   int rsp_idle_pct  = 0;
   int rsp_hold_left = 0;

   always #6 clock = ~clock;

   // advance the dense row by one request; return 1 when it yields a response
   function automatic bit step_dense_row(input logic op, input col_type col,
                                         input value_type a, input value_type b,
                                         output row_entry_type entry);
      longint  prod;
      longint  total;
      col_type c;
      entry = '0;
      if (op == OP_ACCUM) begin
         if (!col_touched[col]) begin
            // drop the whole accumulate when the list has no room
            if (list_len >= COLUMNS) return 1'b0;
            col_touched[col]  = 1'b1;
            nz_cols[list_len] = col;
            list_len++;
         end
         prod  = (longint'(a) * longint'(b)) >>> FRAC_BITS;
         total = longint'(dense_sum[col]) + prod;
         if (total > SUM_MAX) dense_sum[col] = MAX_Q;
         else if (total < SUM_MIN) dense_sum[col] = MIN_Q;
         else dense_sum[col] = value_type'(total);
         return 1'b0;
      end
      // empty row: flag it and rewind
      if (drain_pos >= list_len) begin
         list_len   = 0;
         drain_pos  = 0;
         entry.last = 1'b1;
         return 1'b1;
      end
      c               = nz_cols[drain_pos];
      entry.col       = c;
      entry.value     = dense_sum[c];
      entry.valid_res = 1'b1;
      dense_sum[c]    = '0;
      col_touched[c]  = 1'b0;
      drain_pos++;
      entry.last = (drain_pos >= list_len);
      if (entry.last) begin
         list_len  = 0;
         drain_pos = 0;
      end
      return 1'b1;
   endfunction

   function automatic value_type rand_value();
      case ($urandom_range(7))
         0: return MAX_Q;
         1: return MIN_Q;
         2: return ($urandom_range(1) == 1) ? ALL1 : 32'h0;
         3, 4: return value_type'(int'($urandom_range(20'hFFFFF)) - 32'sh0008_0000);
         default: return value_type'($urandom);
      endcase
   endfunction

   // columns clustered around a base so rows revisit the same entries
   function automatic col_type near_col(input int base);
      return col_type'(base + int'($urandom_range(11)));
   endfunction

   // offer one request after a random gap, hold it until accepted, predict it
   task automatic send_item(input logic op, input col_type col, input value_type a,
                            input value_type b, input logic lit,
                            input row_entry_type lit_entry);
      row_entry_type entry;
      bit            has_rsp;
      @(negedge clock);
      while (int'($urandom_range(99)) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.op      <= op;
      req_if.col     <= col;
      req_if.a_value <= a;
      req_if.b_value <= b;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      has_rsp = step_dense_row(op, col, a, b, entry);
      if (has_rsp) pending_entries.push_back(lit ? lit_entry : entry);
      sent_count++;
   endtask

   task automatic park_req();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   // random rows: accumulate a cluster, then drain it, with noise and breaks
   task automatic random_rows(input int n);
      int stop_at;
      int k;
      int base;
      stop_at = sent_count + n;
      while (sent_count < stop_at) begin
         if ($urandom_range(9) == 0) begin
            send_item(($urandom_range(1) == 1) ? OP_DRAIN : OP_ACCUM,
                      col_type'($urandom), rand_value(), rand_value(), 1'b0, '0);
         end else begin
            k    = ($urandom_range(7) == 0) ? int'($urandom_range(40, 20))
                                            : int'($urandom_range(8, 1));
            base = int'($urandom_range(1023));
            repeat (k) begin
               send_item(OP_ACCUM, near_col(base), rand_value(), rand_value(), 1'b0, '0);
            end
            while (list_len != 0) begin
               if ($urandom_range(15) == 0) begin
                  send_item(OP_ACCUM, near_col(base), rand_value(), rand_value(),
                            1'b0, '0);
               end else if ($urandom_range(31) == 0) begin
                  break;
               end else begin
                  send_item(OP_DRAIN, col_type'($urandom), rand_value(), rand_value(),
                            1'b0, '0);
               end
            end
            if ($urandom_range(5) == 0) begin
               send_item(OP_DRAIN, col_type'($urandom), rand_value(), rand_value(),
                         1'b0, '0);
            end
         end
      end
   endtask

   // receiver: random stalls, or a long hold-off while rsp_hold_left runs
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= (int'($urandom_range(99)) >= rsp_idle_pct);
      end
   end

   // check each response against the oldest predicted entry
   always @(posedge clock) begin
      row_entry_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_entries.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("%0t: unexpected response col %0d value %08h last %0b valid_res %0b",
                        $realtime, rsp_if.out_col, rsp_if.out_value, rsp_if.last,
                        rsp_if.valid_res);
            end
         end else begin
            want = pending_entries.pop_front();
            if (rsp_if.out_col !== want.col || rsp_if.out_value !== want.value ||
                rsp_if.last !== want.last || rsp_if.valid_res !== want.valid_res) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("%0t: expected col %0d value %08h last %0b valid_res %0b",
                           $realtime, want.col, want.value, want.last, want.valid_res);
                  $display("%0t:      got col %0d value %08h last %0b valid_res %0b",
                           $realtime, rsp_if.out_col, rsp_if.out_value, rsp_if.last,
                           rsp_if.valid_res);
               end
            end
         end
      end
   end

   // stop a hung run
   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int            i;
      row_entry_type lit_entry;

      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.op      = OP_ACCUM;
      req_if.col     = '0;
      req_if.a_value = '0;
      req_if.b_value = '0;
      rsp_if.ready   = 1'b0;
      foreach (dense_sum[j]) begin
         dense_sum[j]   = '0;
         col_touched[j] = 1'b0;
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender idles often, receiver stalls most of the time
      req_idle_pct = 34;
      rsp_idle_pct = 87;
      foreach (DIRECTED_ROWS[j]) begin
         lit_entry = '{DIRECTED_ROWS[j].x_col, DIRECTED_ROWS[j].x_value,
                       DIRECTED_ROWS[j].x_last, DIRECTED_ROWS[j].x_valid};
         send_item(DIRECTED_ROWS[j].op, DIRECTED_ROWS[j].col, DIRECTED_ROWS[j].a,
                   DIRECTED_ROWS[j].b, DIRECTED_ROWS[j].lit, lit_entry);
      end
      random_rows(300);

      // swap the idle rates
      req_idle_pct = 87;
      rsp_idle_pct = 34;
      random_rows(300);

      // full rate from here on
      req_idle_pct = 0;
      rsp_idle_pct = 0;

      // hold off the receiver so the core backs up and stalls requests
      rsp_hold_left = 200;
      for (i = 0; i < 24; i++) begin
         send_item((i % 2 == 1) ? OP_DRAIN : OP_ACCUM, near_col(i * 40),
                   rand_value(), rand_value(), 1'b0, '0);
      end
      park_req();
      while (pending_entries.size() != 0) @(posedge clock);

      random_rows(250);

      // drain what is left and let the pipeline settle
      park_req();
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/sra_pkg.sv
sv/sra_if.sv
sv/sra_mac.sv
sv/sparse_row_accumulator_core.sv
dv/sparse_row_accumulator_core_tb.sv
